>>> sv/kmpfms_pkg.sv
// kmpfms_pkg: shared types and constants of the kmp first-match search core
// no dependencies; imported by kmp_first_match_search_core
package kmpfms_pkg;

    // command codes carried in the input transaction
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // fixed width of the reported start index
    localparam int MATCH_START_W = 32;

    // input transaction: one pattern or text byte
    typedef struct packed {
        logic       command;
        logic [7:0] symbol;
        logic       last_symbol;
    } in_item_t;

    // result transaction: match report
    typedef struct packed {
        logic                     found;
        logic [MATCH_START_W-1:0] match_start;
    } out_item_t;

endpackage

>>> sv/kmp_first_match_search_core.sv
// kmp_first_match_search_core: knuth-morris-pratt first-match search over a byte stream
// depends on kmpfms_pkg and kmpfms_ram (pattern store and failure table)
//
//  port group      dir  payload      meaning
//  s_valid/s_ready in   in_item_t    pattern byte (command 0) or text byte (command 1)
//  m_valid/m_ready out  out_item_t   found flag and zero-based start of first match
//
// a pattern byte that starts a pattern or overflows capacity is handled in the idle state; every
// other byte passes through the walk state, one failure-chain step per read of the pattern
// ram and the failure ram (both reads registered).
// reset clears all control state; ram contents are only read after being written.
// a stalled result sits in the output register while the next byte is taken; a second
// result waits in a pending register and holds off input until the output drains.
module kmp_first_match_search_core
    import kmpfms_pkg::*;
#(
    parameter int PATTERN_MAX   = 64,
    parameter int POSITION_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam int SUM_W = POSITION_BITS + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic                       cmd_reg, cmd_next;
    logic [7:0]                 sym_reg, sym_next;
    logic                       last_reg, last_next;
    logic [CNT_W-1:0]           pat_len_reg, pat_len_next;
    logic [IDX_W-1:0]           prefix_reg, prefix_next;
    logic                       sealed_reg, sealed_next;
    logic [IDX_W-1:0]           matched_reg, matched_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic                       reported_reg, reported_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    out_item_t                  pend_reg, pend_next;
    logic                       m_valid_reg, m_valid_next;
    out_item_t                  m_data_reg, m_data_next;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       pat_wdata;
    logic [IDX_W-1:0] fail_wdata;
    logic [7:0]       pat_q;
    logic [IDX_W-1:0] fail_q;

    // chain step and result helpers
    logic                   accept;
    logic                   slot_free;
    logic                   hit;
    logic                   step;
    logic [CNT_W-1:0]       j_len;
    logic [CNT_W-1:0]       eff_len;
    logic [SUM_W-1:0]       pos_plus1;
    logic [SUM_W-1:0]       m_wide;
    logic [SUM_W-1:0]       start_full;

    kmpfms_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX), .ADDR_W(IDX_W)) u_pattern_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (pat_wdata),
        .rd_addr (k_next),
        .rd_data (pat_q)
    );

    kmpfms_ram #(.WIDTH(IDX_W), .DEPTH(PATTERN_MAX), .ADDR_W(IDX_W)) u_failure_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (fail_wdata),
        .rd_addr (k_next - IDX_W'(1)),
        .rd_data (fail_q)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // compare against the byte under test and the resulting prefix length
    assign hit     = (pat_q == sym_reg);
    assign step    = (k_reg != '0) && !hit;
    assign j_len   = CNT_W'(k_reg) + CNT_W'(hit);
    assign eff_len = sealed_reg ? '0 : pat_len_reg;

    // start index of a match ending at the current text byte, floored at zero
    assign pos_plus1  = SUM_W'(pos_reg) + SUM_W'(1);
    assign m_wide     = SUM_W'(pat_len_reg);
    assign start_full = (pos_plus1 >= m_wide) ? (pos_plus1 - m_wide) : '0;

    // sequencer and search state
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        pat_len_next  = pat_len_reg;
        prefix_next   = prefix_reg;
        sealed_next   = sealed_reg;
        matched_next  = matched_reg;
        pos_next      = pos_reg;
        reported_next = reported_reg;
        k_next        = k_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = pat_len_reg[IDX_W-1:0];
        pat_wdata     = sym_reg;
        fail_wdata    = j_len[IDX_W-1:0];
        pend_next.found       = pend_reg.found;
        pend_next.match_start = pend_reg.match_start;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next  = s_data.command;
                    sym_next  = s_data.symbol;
                    last_next = s_data.last_symbol;
                    if (s_data.command == CMD_PATTERN) begin
                        // pattern byte: restart after a sealed pattern, clear the search
                        sealed_next   = s_data.last_symbol;
                        matched_next  = '0;
                        pos_next      = '0;
                        reported_next = 1'b0;
                        pat_len_next  = eff_len;
                        if (sealed_reg) begin
                            prefix_next = '0;
                        end
                        if (eff_len == '0) begin
                            ram_we       = 1'b1;
                            ram_waddr    = '0;
                            pat_wdata    = s_data.symbol;
                            fail_wdata   = '0;
                            prefix_next  = '0;
                            pat_len_next = CNT_W'(1);
                        end else if (eff_len < CNT_W'(PATTERN_MAX)) begin
                            k_next     = prefix_reg;
                            state_next = S_WALK;
                        end
                    end else begin
                        // text byte: walk from the current match length
                        k_next     = matched_reg;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK: begin
                if (cmd_reg == CMD_PATTERN) begin
                    if (step) begin
                        k_next = fail_q;
                    end else begin
                        // append byte and its failure entry
                        ram_we       = 1'b1;
                        prefix_next  = j_len[IDX_W-1:0];
                        pat_len_next = pat_len_reg + CNT_W'(1);
                        state_next   = S_IDLE;
                    end
                end else if (reported_reg) begin
                    // silent until the last text byte
                    if (last_reg) begin
                        matched_next  = '0;
                        pos_next      = '0;
                        reported_next = 1'b0;
                    end else if (pos_reg != '1) begin
                        pos_next = pos_reg + POSITION_BITS'(1);
                    end
                    state_next = S_IDLE;
                end else if (step) begin
                    k_next = fail_q;
                end else begin
                    state_next = S_IDLE;
                    // an empty pattern matches at once without looking at the ram
                    if (pat_len_reg == '0 || j_len >= pat_len_reg) begin
                        pend_next.found       = 1'b1;
                        pend_next.match_start = MATCH_START_W'(start_full);
                        reported_next         = 1'b1;
                        matched_next          = '0;
                        state_next            = S_EMIT;
                    end else begin
                        matched_next = j_len[IDX_W-1:0];
                        if (last_reg) begin
                            pend_next.found       = 1'b0;
                            pend_next.match_start = '0;
                            state_next            = S_EMIT;
                        end
                    end
                    // end of text clears the search
                    if (last_reg) begin
                        matched_next  = '0;
                        pos_next      = '0;
                        reported_next = 1'b0;
                    end else if (pos_reg != '1) begin
                        pos_next = pos_reg + POSITION_BITS'(1);
                    end
                    // hand the result straight to the output register when it is free
                    if (state_next == S_EMIT && slot_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pend_next;
                        state_next   = S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pat_len_reg  <= '0;
            prefix_reg   <= '0;
            sealed_reg   <= 1'b0;
            matched_reg  <= '0;
            pos_reg      <= '0;
            reported_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pat_len_reg  <= pat_len_next;
            prefix_reg   <= prefix_next;
            sealed_reg   <= sealed_next;
            matched_reg  <= matched_next;
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        k_reg      <= k_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> sv/kmpfms_ram.sv
// kmpfms_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module kmpfms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
